// ===== rtl/wsts_pkg.sv =====
// package for the work-stealing task scheduler
// holds field widths, parameter defaults, result codes and the control/status structs
// no dependencies
`default_nettype none

package wsts_pkg;

    // parameter defaults
    localparam int NUM_WORKERS_DEF = 8;
    localparam int STACK_DEPTH_DEF = 256;

    // fixed field widths
    localparam int HANDLE_W = 8;
    localparam int WORKER_W = 3;
    localparam int CFG_W    = 4;

    // result kinds loaded into the output register
    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_PUSH = 2'd1;
    localparam logic [1:0] RES_OVF  = 2'd2;
    localparam logic [1:0] RES_POP  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;       // capture the incoming item
        logic       push;       // write handle, bump own fill count
        logic       pop;        // drop fill count of selected stack, read its top
        logic       ptr_load;   // working pointer = steal pointer + 1
        logic       ptr_sub;    // working pointer -= active count
        logic       ptr_inc;    // working pointer += 1
        logic       advance;    // commit working pointer, switch to victim stack
        logic       res_valid;  // load the output register
        logic [1:0] res_kind;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_range;  // worker below the active count
        logic is_get;
        logic full;      // selected stack is full
        logic empty;     // selected stack is empty
        logic multi;     // more than one active worker
        logic ptr_ge;    // working pointer at or above the active count
        logic ptr_self;  // working pointer names the requesting worker
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/wsts_ctrl.sv =====
// controller state machine for the work-stealing task scheduler
// sequences check, steal-pointer wrap, steal and memory read; uses wsts_pkg
`default_nettype none

module wsts_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire wsts_pkg::status_t status,
    output wsts_pkg::cmd_t        cmd,
    output logic                  busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MOD1  = 3'd2;
    localparam logic [2:0] S_MOD2  = 3'd3;
    localparam logic [2:0] S_STEAL = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = wsts_pkg::RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.in_range)
                begin
                    cmd.res_valid = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (!status.is_get)
                begin
                    cmd.res_valid = 1'b1;
                    if (status.full)
                    begin
                        cmd.res_kind = wsts_pkg::RES_OVF;
                    end
                    else
                    begin
                        cmd.push     = 1'b1;
                        cmd.res_kind = wsts_pkg::RES_PUSH;
                    end
                    state_next = S_IDLE;
                end
                else if (!status.empty)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_READ;
                end
                else if (status.multi)
                begin
                    cmd.ptr_load = 1'b1;
                    state_next   = S_MOD1;
                end
                else
                begin
                    cmd.res_valid = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            // reduce pointer below the active count, then skip own stack
            S_MOD1:
            begin
                if (status.ptr_ge)
                begin
                    cmd.ptr_sub = 1'b1;
                end
                else if (status.ptr_self)
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_MOD2;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_STEAL;
                end
            end
            S_MOD2:
            begin
                if (status.ptr_ge)
                begin
                    cmd.ptr_sub = 1'b1;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_STEAL;
                end
            end
            S_STEAL:
            begin
                if (status.empty)
                begin
                    cmd.res_valid = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.res_valid = 1'b1;
                cmd.res_kind  = wsts_pkg::RES_POP;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/wsts_datapath.sv =====
// datapath for the work-stealing task scheduler
// holds the task memory, fill counts, steal pointers, config and output registers; uses wsts_pkg
`default_nettype none

module wsts_datapath #(
    parameter int NUM_WORKERS = wsts_pkg::NUM_WORKERS_DEF,
    parameter int STACK_DEPTH = wsts_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [wsts_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                          req_type,
    input  wire logic [wsts_pkg::WORKER_W-1:0] worker,
    input  wire logic [wsts_pkg::HANDLE_W-1:0] task_handle,
    input  wire wsts_pkg::cmd_t                cmd,
    output wsts_pkg::status_t                  status,
    output logic                               done,
    output logic                               found,
    output logic [wsts_pkg::HANDLE_W-1:0]      out_handle,
    output logic                               stolen,
    output logic [wsts_pkg::WORKER_W-1:0]      victim,
    output logic                               overflow
);

    localparam int SPW   = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int AW    = $clog2(NUM_WORKERS + 1);
    localparam int FW    = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH = NUM_WORKERS * STACK_DEPTH;
    localparam int MAW   = $clog2(DEPTH);

    // configuration and captured item
    logic [wsts_pkg::CFG_W-1:0]    cfg_reg;
    logic                          get_reg;
    logic [wsts_pkg::WORKER_W-1:0] worker_reg;
    logic [wsts_pkg::HANDLE_W-1:0] handle_reg;
    logic                          steal_mode_reg;
    logic [AW-1:0]                 ptr_reg;
    logic [AW-1:0]                 ptr_next;

    // per-worker state and memory
    logic [FW-1:0]                 fill_reg  [NUM_WORKERS];
    logic [SPW-1:0]                steal_reg [NUM_WORKERS];
    logic [wsts_pkg::HANDLE_W-1:0] mem       [DEPTH];
    logic [wsts_pkg::HANDLE_W-1:0] rd_data_reg;

    // output register
    logic                          done_reg;
    logic                          found_reg;
    logic [wsts_pkg::HANDLE_W-1:0] handle_out_reg;
    logic                          stolen_reg;
    logic [wsts_pkg::WORKER_W-1:0] victim_reg;
    logic                          ovf_reg;

    logic [AW-1:0]  act_cnt;
    logic [SPW-1:0] own_idx;
    logic [SPW-1:0] sel_idx;
    logic [FW-1:0]  fill_sel;
    logic [FW-1:0]  fill_off;
    logic [MAW-1:0] mem_addr;

    // clamp active count to 1..NUM_WORKERS
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            act_cnt = AW'(1);
        end
        else if (int'(cfg_reg) > NUM_WORKERS)
        begin
            act_cnt = AW'(NUM_WORKERS);
        end
        else
        begin
            act_cnt = AW'(cfg_reg);
        end
    end

    // stack selection and memory address
    assign own_idx  = SPW'(worker_reg);
    assign sel_idx  = steal_mode_reg ? ptr_reg[SPW-1:0] : own_idx;
    assign fill_sel = fill_reg[sel_idx];
    assign fill_off = cmd.pop ? (fill_sel - FW'(1)) : fill_sel;
    assign mem_addr = MAW'(sel_idx) * MAW'(STACK_DEPTH) + MAW'(fill_off);

    // status to controller
    always_comb
    begin
        status.in_range = int'(worker_reg) < int'(act_cnt);
        status.is_get   = get_reg;
        status.full     = (int'(fill_sel) >= STACK_DEPTH);
        status.empty    = (fill_sel == '0);
        status.multi    = (act_cnt > AW'(1));
        status.ptr_ge   = (ptr_reg >= act_cnt);
        status.ptr_self = (ptr_reg == AW'(own_idx));
    end

    // working steal pointer
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_load)
        begin
            ptr_next = AW'(steal_reg[own_idx]) + AW'(1);
        end
        else if (cmd.ptr_sub)
        begin
            ptr_next = ptr_reg - act_cnt;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + AW'(1);
        end
    end

    // control registers, fill counts and steal pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= wsts_pkg::CFG_W'(1);
            steal_mode_reg <= 1'b0;
            ptr_reg        <= '0;
            for (int i = 0; i < NUM_WORKERS; i++)
            begin
                fill_reg[i]  <= '0;
                steal_reg[i] <= SPW'(i);
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                steal_mode_reg <= 1'b0;
            end
            else if (cmd.advance)
            begin
                steal_mode_reg <= 1'b1;
            end
            ptr_reg <= ptr_next;
            if (cmd.advance)
            begin
                steal_reg[own_idx] <= ptr_reg[SPW-1:0];
            end
            if (cmd.push)
            begin
                fill_reg[sel_idx] <= fill_sel + FW'(1);
            end
            else if (cmd.pop)
            begin
                fill_reg[sel_idx] <= fill_sel - FW'(1);
            end
        end
    end

    // captured item fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            get_reg    <= req_type;
            worker_reg <= worker;
            handle_reg <= task_handle;
        end
    end

    // task memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[mem_addr] <= handle_reg;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_valid;
        end
    end

    // result fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            handle_out_reg <= '0;
            stolen_reg     <= 1'b0;
            victim_reg     <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (cmd.res_valid)
        begin
            found_reg      <= 1'b0;
            handle_out_reg <= '0;
            stolen_reg     <= 1'b0;
            victim_reg     <= '0;
            ovf_reg        <= 1'b0;
            case (cmd.res_kind)
                wsts_pkg::RES_PUSH:
                begin
                    victim_reg <= worker_reg;
                end
                wsts_pkg::RES_OVF:
                begin
                    victim_reg <= worker_reg;
                    ovf_reg    <= 1'b1;
                end
                wsts_pkg::RES_POP:
                begin
                    found_reg      <= 1'b1;
                    handle_out_reg <= rd_data_reg;
                    stolen_reg     <= steal_mode_reg;
                    victim_reg     <= wsts_pkg::WORKER_W'(sel_idx);
                end
                default:
                begin
                    victim_reg <= '0;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign out_handle = handle_out_reg;
    assign stolen     = stolen_reg;
    assign victim     = victim_reg;
    assign overflow   = ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/work_stealing_task_scheduler_top.sv =====
// Work-stealing task scheduler: one LIFO task stack per worker. start is taken when busy is
// low; each item gives one result on done for a single cycle, which the receiver cannot hold
// off. A push, an out-of-range request or a get that finds its own stack empty with a single
// active worker is decided in the fill count check; a pop from the worker's own stack goes
// through the fill count check, then the registered task memory read. A steal first brings
// the steal pointer below the active count by compare-subtract steps in the shared wrap unit
// (none unless the advanced pointer reaches the active count) and increments it once more,
// with a further wrap if needed, when it lands on the worker itself; it then checks the victim
// stack and, unless that is empty, reads its top from the registered task memory.
// The task memory holds no reset state and needs no clearing pass.
// depends on wsts_pkg, wsts_ctrl, wsts_datapath
`default_nettype none

module work_stealing_task_scheduler_top #(
    parameter int NUM_WORKERS = wsts_pkg::NUM_WORKERS_DEF,
    parameter int STACK_DEPTH = wsts_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [wsts_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic [wsts_pkg::WORKER_W-1:0] worker,
    input  wire logic [wsts_pkg::HANDLE_W-1:0] task_handle,
    output logic                               done,
    output logic                               found,
    output logic [wsts_pkg::HANDLE_W-1:0]      out_handle,
    output logic                               stolen,
    output logic [wsts_pkg::WORKER_W-1:0]      victim,
    output logic                               overflow
);

    wsts_pkg::cmd_t    cmd;
    wsts_pkg::status_t status;

    // sequencer
    wsts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // stacks, pointers and result register
    wsts_datapath #(
        .NUM_WORKERS (NUM_WORKERS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_type    (req_type),
        .worker      (worker),
        .task_handle (task_handle),
        .cmd         (cmd),
        .status      (status),
        .done        (done),
        .found       (found),
        .out_handle  (out_handle),
        .stolen      (stolen),
        .victim      (victim),
        .overflow    (overflow)
    );

    // result always lands after the sequencer has returned to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // an accepted item occupies the sequencer in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("item accepted but sequencer idle");

    // a result is either a handed-out task or an overflow, never both
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !(found && overflow))
        else $error("found and overflow together");

    // no task handed out means a zero handle and no steal
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (out_handle == '0 && !stolen))
        else $error("handle or steal flag without a task");

endmodule

`default_nettype wire
